@@ rtl/core/fte_pkg.sv @@
`timescale 1ns / 1ps

package fte_pkg;

  // Field widths
  localparam int COORD_W     = 32;
  localparam int FACE_W      = 16;
  localparam int PROJ_W      = 64;
  localparam int EXT_W       = 21;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  // Texel size, a power of two; projections are Q31.32
  localparam int TEXEL_SIZE   = 16;
  localparam int STEP_SHIFT   = $clog2(TEXEL_SIZE) + 32;
  localparam int QUOT_W       = PROJ_W - STEP_SHIFT;

  // Running extent sentinels in Q31.32
  localparam logic signed [PROJ_W-1:0] MIN_SENTINEL = 64'sd999999 <<< 32;
  localparam logic signed [PROJ_W-1:0] MAX_SENTINEL = -(64'sd99999 <<< 32);

  // Output clamp limits
  localparam logic signed [EXT_W-1:0] EXT_HIGH = {1'b0, {(EXT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] EXT_LOW  = {1'b1, {(EXT_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_S_AXIS_X = 4'd0,
    REG_S_AXIS_Y = 4'd1,
    REG_S_AXIS_Z = 4'd2,
    REG_S_SHIFT  = 4'd3,
    REG_T_AXIS_X = 4'd4,
    REG_T_AXIS_Y = 4'd5,
    REG_T_AXIS_Z = 4'd6,
    REG_T_SHIFT  = 4'd7
  } cfg_reg_t;

  // One texture axis with its offset, Q15.16
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] shift;
  } axis_t;

  // Queue entry between front and back
  typedef struct packed {
    logic signed [PROJ_W-1:0] proj_s;
    logic signed [PROJ_W-1:0] proj_t;
    logic                     last;
    logic [FACE_W-1:0]        face;
  } qitem_t;

  // Exact Q15.16 x Q15.16 product in Q31.32
  function automatic logic signed [PROJ_W-1:0] mul32(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    logic signed [PROJ_W-1:0] wa;
    logic signed [PROJ_W-1:0] wb;
    wa = PROJ_W'(a);
    wb = PROJ_W'(b);
    mul32 = wa * wb;
  endfunction

  // 64-bit add saturating to the signed range
  function automatic logic signed [PROJ_W-1:0] sat_add64(input logic signed [PROJ_W-1:0] a,
                                                        input logic signed [PROJ_W-1:0] b);
    logic signed [PROJ_W:0] s;
    s = {a[PROJ_W-1], a} + {b[PROJ_W-1], b};
    if (s[PROJ_W] != s[PROJ_W-1]) begin
      sat_add64 = s[PROJ_W] ? {1'b1, {(PROJ_W-1){1'b0}}} : {1'b0, {(PROJ_W-1){1'b1}}};
    end else begin
      sat_add64 = s[PROJ_W-1:0];
    end
  endfunction

  // Q15.16 offset widened to Q31.32
  function automatic logic signed [PROJ_W-1:0] shift_q32(input logic signed [COORD_W-1:0] sh);
    shift_q32 = {{(PROJ_W-COORD_W-16){sh[COORD_W-1]}}, sh, 16'b0};
  endfunction

endpackage

@@ rtl/core/fte_vertex_if.sv @@
`timescale 1ns / 1ps

interface fte_vertex_if;
  import fte_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] vertex_z;
  logic                      last_vertex;
  logic [FACE_W-1:0]         face_index;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, face_index,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, face_index,
                  output ready);
endinterface

@@ rtl/core/fte_extents_if.sv @@
`timescale 1ns / 1ps

interface fte_extents_if;
  import fte_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FACE_W-1:0]       done_face;
  logic signed [EXT_W-1:0] min_s;
  logic signed [EXT_W-1:0] min_t;
  logic signed [EXT_W-1:0] max_s;
  logic signed [EXT_W-1:0] max_t;

  modport source (output valid, done_face, min_s, min_t, max_s, max_t, input ready);
  modport sink   (input valid, done_face, min_s, min_t, max_s, max_t, output ready);
endinterface

@@ rtl/core/fte_front.sv @@
`timescale 1ns / 1ps

// Projection pipeline: products, then three saturating adds in source order
module fte_front import fte_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] vertex_x,
  input  logic signed [COORD_W-1:0] vertex_y,
  input  logic signed [COORD_W-1:0] vertex_z,
  input  logic                      last_vertex,
  input  logic [FACE_W-1:0]         face_index,
  input  axis_t                     s_axis,
  input  axis_t                     t_axis,
  output logic                      push,
  output qitem_t                    push_item,
  input  logic                      full
);

  logic v1, v2, v3;
  logic adv;

  // stage 1: products
  logic signed [PROJ_W-1:0] psx, psy, psz, ptx, pty, ptz;
  logic                     last1;
  logic [FACE_W-1:0]        face1;
  // stage 2: x+y, z carried
  logic signed [PROJ_W-1:0] s1_s, s1_t, pz_s, pz_t;
  logic                     last2;
  logic [FACE_W-1:0]        face2;
  // stage 3: +z
  logic signed [PROJ_W-1:0] s2_s, s2_t;
  logic                     last3;
  logic [FACE_W-1:0]        face3;

  // whole pipe holds when the queue cannot take the head
  assign adv      = !(v3 && full);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      psx   <= mul32(vertex_x, s_axis.x);
      psy   <= mul32(vertex_y, s_axis.y);
      psz   <= mul32(vertex_z, s_axis.z);
      ptx   <= mul32(vertex_x, t_axis.x);
      pty   <= mul32(vertex_y, t_axis.y);
      ptz   <= mul32(vertex_z, t_axis.z);
      last1 <= last_vertex;
      face1 <= face_index;

      s1_s  <= sat_add64(psx, psy);
      s1_t  <= sat_add64(ptx, pty);
      pz_s  <= psz;
      pz_t  <= ptz;
      last2 <= last1;
      face2 <= face1;

      s2_s  <= sat_add64(s1_s, pz_s);
      s2_t  <= sat_add64(s1_t, pz_t);
      last3 <= last2;
      face3 <= face2;
    end
  end

  // last add (offset) feeds the queue directly
  assign push             = v3 && !full;
  assign push_item.proj_s = sat_add64(s2_s, shift_q32(s_axis.shift));
  assign push_item.proj_t = sat_add64(s2_t, shift_q32(t_axis.shift));
  assign push_item.last   = last3;
  assign push_item.face   = face3;

endmodule

@@ rtl/core/fte_queue.sv @@
`timescale 1ns / 1ps

// Four-entry queue of projected vertices
module fte_queue import fte_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output qitem_t pop_item
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  qitem_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

@@ rtl/core/fte_back.sv @@
`timescale 1ns / 1ps

// Running min/max per axis, then divide by the step and clamp
module fte_back import fte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    not_empty,
  input  qitem_t                  q_item,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FACE_W-1:0]       done_face,
  output logic signed [EXT_W-1:0] min_s,
  output logic signed [EXT_W-1:0] min_t,
  output logic signed [EXT_W-1:0] max_s,
  output logic signed [EXT_W-1:0] max_t
);

  logic signed [PROJ_W-1:0] run_min_s, run_min_t, run_max_s, run_max_t;
  logic signed [PROJ_W-1:0] nmin_s, nmin_t, nmax_s, nmax_t;

  // finished face, waiting for the output register
  logic                     ext_valid;
  logic signed [PROJ_W-1:0] ext_min_s, ext_min_t, ext_max_s, ext_max_t;
  logic [FACE_W-1:0]        ext_face;
  logic                     ext_move;
  logic                     ext_free;

  function automatic logic signed [EXT_W-1:0] clamp_ext(input logic signed [QUOT_W:0] v);
    if (v > (QUOT_W+1)'(EXT_HIGH)) begin
      clamp_ext = EXT_HIGH;
    end else if (v < (QUOT_W+1)'(EXT_LOW)) begin
      clamp_ext = EXT_LOW;
    end else begin
      clamp_ext = v[EXT_W-1:0];
    end
  endfunction

  function automatic logic signed [QUOT_W:0] div_floor(input logic signed [PROJ_W-1:0] v);
    div_floor = {v[PROJ_W-1], v[PROJ_W-1:STEP_SHIFT]};
  endfunction

  function automatic logic signed [QUOT_W:0] div_ceil(input logic signed [PROJ_W-1:0] v);
    logic signed [QUOT_W:0] q;
    q = {v[PROJ_W-1], v[PROJ_W-1:STEP_SHIFT]};
    div_ceil = q + (QUOT_W+1)'(|v[STEP_SHIFT-1:0]);
  endfunction

  assign ext_move = ext_valid && (!out_valid || out_ready);
  assign ext_free = !ext_valid || ext_move;
  // a plain vertex never waits on the result side
  assign pop      = not_empty && (!q_item.last || ext_free);

  always_comb begin
    nmin_s = (q_item.proj_s < run_min_s) ? q_item.proj_s : run_min_s;
    nmin_t = (q_item.proj_t < run_min_t) ? q_item.proj_t : run_min_t;
    nmax_s = (q_item.proj_s > run_max_s) ? q_item.proj_s : run_max_s;
    nmax_t = (q_item.proj_t > run_max_t) ? q_item.proj_t : run_max_t;
  end

  // running extents
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_s <= MIN_SENTINEL;
      run_min_t <= MIN_SENTINEL;
      run_max_s <= MAX_SENTINEL;
      run_max_t <= MAX_SENTINEL;
    end else if (pop) begin
      if (q_item.last) begin
        run_min_s <= MIN_SENTINEL;
        run_min_t <= MIN_SENTINEL;
        run_max_s <= MAX_SENTINEL;
        run_max_t <= MAX_SENTINEL;
      end else begin
        run_min_s <= nmin_s;
        run_min_t <= nmin_t;
        run_max_s <= nmax_s;
        run_max_t <= nmax_t;
      end
    end
  end

  // finished-face stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_valid <= 1'b0;
    end else if (pop && q_item.last) begin
      ext_valid <= 1'b1;
    end else if (ext_move) begin
      ext_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      ext_min_s <= nmin_s;
      ext_min_t <= nmin_t;
      ext_max_s <= nmax_s;
      ext_max_t <= nmax_t;
      ext_face  <= q_item.face;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ext_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ext_move) begin
      done_face <= ext_face;
      min_s     <= clamp_ext(div_floor(ext_min_s));
      min_t     <= clamp_ext(div_floor(ext_min_t));
      max_s     <= clamp_ext(div_ceil(ext_max_s));
      max_t     <= clamp_ext(div_ceil(ext_max_t));
    end
  end

endmodule

@@ rtl/core/face_texture_extents_unit.sv @@
`timescale 1ns / 1ps

// Texture extents of a face, one vertex per clock while the queue is not full. Each
// accepted vertex is projected onto the S and T axes (exact Q31.32 products,
// saturating sums) in a three-stage multiplier pipeline, passes a four-entry queue,
// and updates the running min/max; on the vertex marked last the block delivers
// floor(min/16) and ceil(max/16) per axis, clamped to 21 bits, and restarts from
// the sentinels. Sustained rate is one vertex per cycle while the queue is not full,
// set by the pipelined multipliers and the registered min/max update. A face's result
// passes the queue, finished-face and output registers; a held result stalls input
// only once the queue fills. The user must write axis registers through the cfg port
// only while no face is in flight; the block itself does not enforce this.
module face_texture_extents_unit import fte_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  fte_vertex_if.sink             vertex,
  fte_extents_if.source          extents,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  axis_t  s_axis;
  axis_t  t_axis;
  logic   push;
  qitem_t push_item;
  logic   full;
  logic   pop;
  logic   not_empty;
  qitem_t pop_item;

  // axis register file
  always_ff @(posedge clk) begin
    if (rst) begin
      s_axis <= '{x: 32'sd65536, y: '0, z: '0, shift: '0};
      t_axis <= '{x: '0, y: 32'sd65536, z: '0, shift: '0};
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_S_AXIS_X: s_axis.x     <= cfg_data;
        REG_S_AXIS_Y: s_axis.y     <= cfg_data;
        REG_S_AXIS_Z: s_axis.z     <= cfg_data;
        REG_S_SHIFT:  s_axis.shift <= cfg_data;
        REG_T_AXIS_X: t_axis.x     <= cfg_data;
        REG_T_AXIS_Y: t_axis.y     <= cfg_data;
        REG_T_AXIS_Z: t_axis.z     <= cfg_data;
        REG_T_SHIFT:  t_axis.shift <= cfg_data;
        default: ;
      endcase
    end
  end

  fte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (vertex.valid),
    .in_ready    (vertex.ready),
    .vertex_x    (vertex.vertex_x),
    .vertex_y    (vertex.vertex_y),
    .vertex_z    (vertex.vertex_z),
    .last_vertex (vertex.last_vertex),
    .face_index  (vertex.face_index),
    .s_axis      (s_axis),
    .t_axis      (t_axis),
    .push        (push),
    .push_item   (push_item),
    .full        (full)
  );

  fte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  fte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (extents.valid),
    .out_ready (extents.ready),
    .done_face (extents.done_face),
    .min_s     (extents.min_s),
    .min_t     (extents.min_t),
    .max_s     (extents.max_s),
    .max_t     (extents.max_t)
  );

endmodule

@@ rtl/core/fte_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the extents unit
module fte_checker import fte_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [FACE_W-1:0]       done_face,
  input logic signed [EXT_W-1:0] min_s,
  input logic signed [EXT_W-1:0] min_t,
  input logic signed [EXT_W-1:0] max_s,
  input logic signed [EXT_W-1:0] max_t
);

  // faces taken in but not yet delivered
  logic [7:0] pending;
  logic       in_req;
  logic       out_req;

  assign in_req  = in_valid && in_ready && in_last;
  assign out_req = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_req && !out_req) begin
      pending <= pending + 1'b1;
    end else if (out_req && !in_req && pending != '0) begin
      pending <= pending - 1'b1;
    end
  end

  // every face has a vertex, so min never passes max
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_s <= max_s) && (min_t <= max_t))
    else $error("extents out of order");

  // no result without a last vertex behind it
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_req |-> pending != '0)
    else $error("result without a pending face");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(done_face) && $stable(min_s)
      && $stable(min_t) && $stable(max_s) && $stable(max_t))
    else $error("stalled result changed");

endmodule

bind face_texture_extents_unit fte_checker u_fte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vertex.valid),
  .in_ready  (vertex.ready),
  .in_last   (vertex.last_vertex),
  .out_valid (extents.valid),
  .out_ready (extents.ready),
  .done_face (extents.done_face),
  .min_s     (extents.min_s),
  .min_t     (extents.min_t),
  .max_s     (extents.max_s),
  .max_t     (extents.max_t)
);

@@ tb/face_texture_extents_unit_tb.sv @@
`timescale 1ns / 1ps

module face_texture_extents_unit_tb;
  import fte_pkg::*;

  localparam int NUM_REGS = REG_T_SHIFT + 1;
  localparam int CFG_SLOTS = 1 << CFG_INDEX_W;
  localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint TEXEL_Q32 = longint'(TEXEL_SIZE) <<< 32;
  localparam longint START_MIN = 64'sd999999 <<< 32;
  localparam longint START_MAX = -(64'sd99999 <<< 32);
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 24;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int NUM_PHASES = 14;
  localparam int NUM_AXES_KINDS = 7;
  localparam int NUM_IDLE_MODES = 4;
  localparam int IDLE_PCT = 52;
  localparam int BOTH_IDLE_PCT = 28;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef enum {
    AXES_RANDOM,
    AXES_MAX,
    AXES_MIN,
    AXES_SMALL,
    AXES_SHIFT_ONLY,
    AXES_UNIT,
    AXES_MIXED
  } axes_kind_e;

  typedef enum {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
    logic [FACE_W-1:0]         face;
  } vertex_req_t;

  typedef struct {
    logic [FACE_W-1:0]       face;
    logic signed [EXT_W-1:0] min_s;
    logic signed [EXT_W-1:0] min_t;
    logic signed [EXT_W-1:0] max_s;
    logic signed [EXT_W-1:0] max_t;
  } extents_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fte_vertex_if  vtx ();
  fte_extents_if ext ();

  face_texture_extents_unit dut (
    .clk       (clk),
    .rst       (rst),
    .vertex    (vtx),
    .extents   (ext),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the axis registers and of the running extents
  logic signed [COORD_W-1:0] axis_cfg [NUM_REGS];
  longint low_s, low_t, high_s, high_t;

  vertex_req_t vertex_q [$];
  extents_t    extents_exp_q [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Extent math
  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
    if (b < 0 && a < ACC_MIN - b) return ACC_MIN;
    return a + b;
  endfunction

  function automatic longint project_axis(longint x, longint y, longint z,
                                          longint ax, longint ay, longint az, longint sh);
    longint acc;
    acc = x * ax;
    acc = sat_sum(acc, y * ay);
    acc = sat_sum(acc, z * az);
    return sat_sum(acc, sh <<< 16);
  endfunction

  function automatic logic signed [EXT_W-1:0] clamp_ext(longint q);
    if (q > EXT_HIGH) return EXT_HIGH;
    if (q < EXT_LOW) return EXT_LOW;
    return EXT_W'(q);
  endfunction

  function automatic logic signed [EXT_W-1:0] floor_texel(longint v);
    longint q;
    q = v / TEXEL_Q32;
    if (v % TEXEL_Q32 < 0) q--;
    return clamp_ext(q);
  endfunction

  function automatic logic signed [EXT_W-1:0] ceil_texel(longint v);
    longint q;
    q = v / TEXEL_Q32;
    if (v % TEXEL_Q32 > 0) q++;
    return clamp_ext(q);
  endfunction

  function automatic void restart_running();
    low_s = START_MIN;
    low_t = START_MIN;
    high_s = START_MAX;
    high_t = START_MAX;
  endfunction

  // Fold one vertex into the running extents; a last vertex closes the face
  function automatic void absorb_vertex(vertex_req_t v);
    longint ps, pt;
    extents_t e;
    ps = project_axis(v.x, v.y, v.z, axis_cfg[REG_S_AXIS_X], axis_cfg[REG_S_AXIS_Y],
                      axis_cfg[REG_S_AXIS_Z], axis_cfg[REG_S_SHIFT]);
    pt = project_axis(v.x, v.y, v.z, axis_cfg[REG_T_AXIS_X], axis_cfg[REG_T_AXIS_Y],
                      axis_cfg[REG_T_AXIS_Z], axis_cfg[REG_T_SHIFT]);
    if (ps < low_s) low_s = ps;
    if (ps > high_s) high_s = ps;
    if (pt < low_t) low_t = pt;
    if (pt > high_t) high_t = pt;
    if (v.last) begin
      e.face = v.face;
      e.min_s = floor_texel(low_s);
      e.min_t = floor_texel(low_t);
      e.max_s = ceil_texel(high_s);
      e.max_t = ceil_texel(high_t);
      extents_exp_q.push_back(e);
      restart_running();
    end
  endfunction

  function automatic void report_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Stimulus helpers
  function automatic logic signed [COORD_W-1:0] rand_signed(int bits);
    int span, r;
    span = 1 << bits;
    r = $urandom_range(2 * span, 0);
    return r - span;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return '1;
      default: return ONE_Q16;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return pick_extreme();
      default: return rand_signed(23);
    endcase
  endfunction

  function automatic void push_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                      logic signed [COORD_W-1:0] z, logic last,
                                      logic [FACE_W-1:0] face);
    vertex_req_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.last = last;
    v.face = face;
    vertex_q.push_back(v);
  endfunction

  // Queue one face of random length; returns its vertex count
  function automatic int queue_random_face();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
    for (int i = 0; i < len; i++)
      push_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1, FACE_W'($urandom));
    return len;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx < NUM_REGS) axis_cfg[idx] = data;
  endtask

  // Program all axis registers, then one write to an unused index
  task automatic load_axes(input axes_kind_e kind);
    logic [CFG_DATA_W-1:0] vals [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) begin
      case (kind)
        AXES_RANDOM: vals[i] = $urandom;
        AXES_MAX: vals[i] = COORD_MAX;
        AXES_MIN: vals[i] = COORD_MIN;
        AXES_SMALL: begin
          vals[i] = (i == REG_S_SHIFT || i == REG_T_SHIFT) ? rand_signed(26) : rand_signed(18);
        end
        AXES_SHIFT_ONLY: begin
          vals[i] = (i == REG_S_SHIFT || i == REG_T_SHIFT) ? $urandom : '0;
        end
        AXES_UNIT: begin
          vals[i] = (i == REG_S_SHIFT || i == REG_T_SHIFT) ? rand_signed(24) : '0;
        end
        default: vals[i] = (i == REG_S_SHIFT || i == REG_T_SHIFT) ? $urandom : pick_extreme();
      endcase
    end
    if (kind == AXES_UNIT) begin
      vals[REG_S_AXIS_X] = ONE_Q16;
      vals[REG_T_AXIS_Y] = ONE_Q16;
    end
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_INDEX_W'(i), vals[i]);
    write_reg(CFG_INDEX_W'($urandom_range(CFG_SLOTS - 1, NUM_REGS)), $urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin gap_pct = 0; stall_pct = 0; end
      IDLE_SEND: begin gap_pct = IDLE_PCT; stall_pct = 0; end
      IDLE_RECV: begin gap_pct = 0; stall_pct = IDLE_PCT; end
      default: begin gap_pct = BOTH_IDLE_PCT; stall_pct = BOTH_IDLE_PCT; end
    endcase
  endtask

  // Wait for every queued vertex and every face result, then let the pipe empty
  task automatic settle();
    while (vertex_q.size() != 0 || vtx.valid || extents_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Vertex driver
  always @(posedge clk) begin : drive_vertices
    vertex_req_t v;
    if (rst) begin
      vtx.valid <= 1'b0;
    end else if (!vtx.valid || vtx.ready) begin
      if (vertex_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        v = vertex_q.pop_front();
        vtx.valid <= 1'b1;
        vtx.vertex_x <= v.x;
        vtx.vertex_y <= v.y;
        vtx.vertex_z <= v.z;
        vtx.last_vertex <= v.last;
        vtx.face_index <= v.face;
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted vertex request
  always @(posedge clk) begin : predict_extents
    vertex_req_t v;
    if (!rst && vtx.valid && vtx.ready) begin
      v.x = vtx.vertex_x;
      v.y = vtx.vertex_y;
      v.z = vtx.vertex_z;
      v.last = vtx.last_vertex;
      v.face = vtx.face_index;
      absorb_vertex(v);
    end
  end

  // Result backpressure
  always @(posedge clk) begin
    if (rst) begin
      ext.ready <= 1'b0;
    end else begin
      ext.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every accepted result request against the oldest expectation
  always @(posedge clk) begin : check_extents
    extents_t e;
    if (!rst && ext.valid && ext.ready) begin
      if (extents_exp_q.size() == 0) begin
        report_error($sformatf("extents for face %0d with no face pending", ext.done_face));
      end else begin
        e = extents_exp_q.pop_front();
        if (ext.done_face !== e.face || ext.min_s !== e.min_s || ext.min_t !== e.min_t ||
            ext.max_s !== e.max_s || ext.max_t !== e.max_t) begin
          report_error($sformatf(
            "exp face %0d s [%0d,%0d] t [%0d,%0d], got face %0d s [%0d,%0d] t [%0d,%0d]",
            e.face, e.min_s, e.max_s, e.min_t, e.max_t, ext.done_face, ext.min_s,
            ext.max_s, ext.min_t, ext.max_t));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    // Register reset values: S along x, T along y, no offsets
    foreach (axis_cfg[i]) axis_cfg[i] = '0;
    axis_cfg[REG_S_AXIS_X] = ONE_Q16;
    axis_cfg[REG_T_AXIS_Y] = ONE_Q16;
    restart_running();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed faces under reset axes
    set_idle(IDLE_NONE);
    push_vertex('0, '0, '0, 1'b1, '0);
    push_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, '1);
    push_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 16'h8000);
    // three vertices, inner face numbers ignored
    push_vertex(32'sh0010_0000, 32'shFFF0_0000, '0, 1'b0, 16'h1234);
    push_vertex(32'shFFFF_8000, 32'sh001F_8000, COORD_MAX, 1'b0, 16'h00FF);
    push_vertex(32'sh0064_4000, 32'sh0000_0001, COORD_MIN, 1'b1, 16'h0042);
    // exactly on a texel edge, and one LSB off either side
    push_vertex(32'sh0010_0000, 32'shFFFF_FFFF, '0, 1'b1, 16'h0001);
    push_vertex(32'shFFF0_0000, 32'sh0000_0001, '0, 1'b1, 16'h0002);
    n = queue_random_face();
    n = queue_random_face();
    settle();

    // Random phases over axis settings and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_axes(axes_kind_e'(p % NUM_AXES_KINDS));
      set_idle(idle_mode_e'(p % NUM_IDLE_MODES));
      // all-max and all-min vertices push sums into saturation or leave a sentinel
      push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, FACE_W'($urandom));
      push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, FACE_W'($urandom));
      n = 2;
      while (n < ITEMS_PER_PHASE) n += queue_random_face();
      settle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
